// ===== hdl/bounding_box_and_spacing_assert.svh =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: assertion macros
// Shared wrappers for concurrent assertions, clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef BOUNDING_BOX_AND_SPACING_ASSERT_SVH
`define BOUNDING_BOX_AND_SPACING_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define BBS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bbs assertion failed");

// Assertion that also holds across reset.
`define BBS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bbs assertion failed");

`endif

// ===== hdl/bbs_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: package
// Field widths, mode codes, reset values and the controller command bundle.
// ---------------------------------------------------------------------------
package bbs_pkg;

  localparam int COORD_W = 32;
  localparam int REC_W   = 32;
  localparam int SUB_W   = 16;
  localparam int MODE_W  = 2;
  localparam int SUM_W   = 57;
  localparam int CNT_W   = 25;
  localparam int BOX_W   = 34;
  localparam int GRID_W  = 33;

  localparam int MAX_POINTS = 16777216;

  // Neighbor distance limit for record and sub-record tests
  localparam int NEAR_LIMIT = 3;

  // 5% margin as a Q16 multiplier
  localparam int MARGIN_MULT   = 3277;
  localparam int MARGIN_MULT_W = 12;
  localparam int MARGIN_SHIFT  = 16;
  localparam int PROD_W        = COORD_W + MARGIN_MULT_W;
  localparam int MARG_W        = PROD_W - MARGIN_SHIFT;

  // Divider: numerator is twice the step sum
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [MODE_W-1:0] MODE_SAME_REC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEAR_REC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NO_SPACE = 2'd2;

  localparam logic signed [COORD_W-1:0] COORD_POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic accept;    // point taken this cycle
    logic finish;    // point taken and it closes the batch
    logic div_step;  // advance both dividers one bit
    logic out_load;  // capture a result into the output register
  } cmd_t;

endpackage

// ===== hdl/bbs_if.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: channel interfaces
// Valid/ready channels for configuration, points and results.
// ---------------------------------------------------------------------------
interface bbs_cfg_if;
  import bbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] spacing_mode;
  modport source (output valid, output spacing_mode, input ready);
  modport sink   (input valid, input spacing_mode, output ready);
endinterface

interface bbs_in_if;
  import bbs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic [REC_W-1:0]          record_number;
  logic [SUB_W-1:0]          sub_record;
  logic                      is_last;
  modport source (output valid, output x_coord, output y_coord, output record_number,
                  output sub_record, output is_last, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input record_number,
                  input sub_record, input is_last, output ready);
endinterface

interface bbs_out_if;
  import bbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [BOX_W-1:0] box_min_x;
  logic signed [BOX_W-1:0] box_max_x;
  logic signed [BOX_W-1:0] box_min_y;
  logic signed [BOX_W-1:0] box_max_y;
  logic [GRID_W-1:0]       grid_x;
  logic [GRID_W-1:0]       grid_y;
  logic [CNT_W-1:0]        total_points;
  logic                    spacing_valid;
  modport source (output valid, output box_min_x, output box_max_x, output box_min_y,
                  output box_max_y, output grid_x, output grid_y, output total_points,
                  output spacing_valid, input ready);
  modport sink   (input valid, input box_min_x, input box_max_x, input box_min_y,
                  input box_max_y, input grid_x, input grid_y, input total_points,
                  input spacing_valid, output ready);
endinterface

// ===== hdl/bbs_divider.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: radix-2 divider
// Restoring divide, one quotient bit per step; quotient replaces numerator.
// ---------------------------------------------------------------------------
module bbs_divider (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic [bbs_pkg::NUM_W-1:0]  num_in,
  input  logic [bbs_pkg::CNT_W-1:0]  den_in,
  output logic [bbs_pkg::NUM_W-1:0]  quo
);
  import bbs_pkg::*;

  logic [NUM_W-1:0] num;
  logic [CNT_W-1:0] den;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_sub;
  logic             fits;

  assign rem_sh  = {rem, num[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      num <= num_in;
      den <= den_in;
      rem <= '0;
    end else if (step) begin
      num <= {num[NUM_W-2:0], fits};
      rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign quo = num;

endmodule

// ===== hdl/bbs_datapath.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: datapath
// Running extremes, neighbor step sums, margin multiply, dividers, result reg.
// ---------------------------------------------------------------------------
module bbs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  bbs_pkg::cmd_t                     cmd,
  input  logic                              cfg_we,
  input  logic [bbs_pkg::MODE_W-1:0]        cfg_mode,
  input  logic signed [bbs_pkg::COORD_W-1:0] x_coord,
  input  logic signed [bbs_pkg::COORD_W-1:0] y_coord,
  input  logic [bbs_pkg::REC_W-1:0]         record_number,
  input  logic [bbs_pkg::SUB_W-1:0]         sub_record,
  output logic signed [bbs_pkg::BOX_W-1:0]  box_min_x,
  output logic signed [bbs_pkg::BOX_W-1:0]  box_max_x,
  output logic signed [bbs_pkg::BOX_W-1:0]  box_min_y,
  output logic signed [bbs_pkg::BOX_W-1:0]  box_max_y,
  output logic [bbs_pkg::GRID_W-1:0]        grid_x,
  output logic [bbs_pkg::GRID_W-1:0]        grid_y,
  output logic [bbs_pkg::CNT_W-1:0]         total_points,
  output logic                              spacing_valid
);
  import bbs_pkg::*;

  logic [MODE_W-1:0] mode;

  // running state
  logic signed [COORD_W-1:0] run_min_x, run_max_x, run_min_y, run_max_y;
  logic signed [COORD_W-1:0] prev_x, prev_y;
  logic [REC_W-1:0]          prev_record;
  logic [SUB_W-1:0]          prev_sub;
  logic                      have_prev;
  logic [SUM_W-1:0]          step_sum_x, step_sum_y;
  logic [CNT_W-1:0]          pair_count, point_count;

  logic signed [COORD_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
  logic [SUM_W-1:0]          sum_x_next, sum_y_next;
  logic [CNT_W-1:0]          pair_next, point_next;

  logic [COORD_W:0] dx_raw, dy_raw;
  logic [COORD_W-1:0] dx_abs, dy_abs;
  logic [REC_W:0]   drec_raw;
  logic [REC_W-1:0] drec_abs;
  logic [SUB_W:0]   dsub_raw;
  logic [SUB_W-1:0] dsub_abs;
  logic             rec_near, sub_near, rec_same, rule_ok, take_pair;

  // finishing stage
  logic signed [COORD_W-1:0] snap_min_x, snap_max_x, snap_min_y, snap_max_y;
  logic [CNT_W-1:0]          snap_points;
  logic                      snap_has_pairs;
  logic [COORD_W-1:0]        ext_x, ext_y;
  logic [PROD_W-1:0]         prod_x, prod_y;
  logic [MARG_W-1:0]         marg_x, marg_y;
  logic [NUM_W-1:0]          quo_x, quo_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SAME_REC;
    end else if (cfg_we) begin
      mode <= cfg_mode;
    end
  end

  // extremes
  assign min_x_next = (x_coord < run_min_x) ? x_coord : run_min_x;
  assign max_x_next = (x_coord > run_max_x) ? x_coord : run_max_x;
  assign min_y_next = (y_coord < run_min_y) ? y_coord : run_min_y;
  assign max_y_next = (y_coord > run_max_y) ? y_coord : run_max_y;

  // absolute steps; the true difference always fits the unsigned width
  assign dx_raw = {x_coord[COORD_W-1], x_coord} - {prev_x[COORD_W-1], prev_x};
  assign dy_raw = {y_coord[COORD_W-1], y_coord} - {prev_y[COORD_W-1], prev_y};
  assign dx_abs = dx_raw[COORD_W] ? COORD_W'(-dx_raw) : dx_raw[COORD_W-1:0];
  assign dy_abs = dy_raw[COORD_W] ? COORD_W'(-dy_raw) : dy_raw[COORD_W-1:0];

  assign drec_raw = {1'b0, record_number} - {1'b0, prev_record};
  assign drec_abs = drec_raw[REC_W] ? REC_W'(-drec_raw) : drec_raw[REC_W-1:0];
  assign dsub_raw = {1'b0, sub_record} - {1'b0, prev_sub};
  assign dsub_abs = dsub_raw[SUB_W] ? SUB_W'(-dsub_raw) : dsub_raw[SUB_W-1:0];

  assign rec_same = record_number == prev_record;
  assign rec_near = drec_abs < REC_W'(NEAR_LIMIT);
  assign sub_near = dsub_abs < SUB_W'(NEAR_LIMIT);

  always_comb begin
    case (mode)
      MODE_SAME_REC: rule_ok = rec_same && sub_near;
      MODE_NEAR_REC: rule_ok = rec_near;
      default:       rule_ok = 1'b0;
    endcase
  end

  assign take_pair = have_prev && rule_ok && (pair_count < CNT_W'(MAX_POINTS - 1));

  assign sum_x_next = take_pair ? step_sum_x + SUM_W'(dx_abs) : step_sum_x;
  assign sum_y_next = take_pair ? step_sum_y + SUM_W'(dy_abs) : step_sum_y;
  assign pair_next  = take_pair ? pair_count + 1'b1 : pair_count;
  assign point_next = (point_count < CNT_W'(MAX_POINTS)) ? point_count + 1'b1 : point_count;

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      run_min_x   <= COORD_POS_MAX;
      run_max_x   <= COORD_NEG_MAX;
      run_min_y   <= COORD_POS_MAX;
      run_max_y   <= COORD_NEG_MAX;
      prev_x      <= '0;
      prev_y      <= '0;
      prev_record <= '0;
      prev_sub    <= '0;
      have_prev   <= 1'b0;
      step_sum_x  <= '0;
      step_sum_y  <= '0;
      pair_count  <= '0;
      point_count <= '0;
    end else if (cmd.accept) begin
      run_min_x   <= min_x_next;
      run_max_x   <= max_x_next;
      run_min_y   <= min_y_next;
      run_max_y   <= max_y_next;
      prev_x      <= x_coord;
      prev_y      <= y_coord;
      prev_record <= record_number;
      prev_sub    <= sub_record;
      have_prev   <= 1'b1;
      step_sum_x  <= sum_x_next;
      step_sum_y  <= sum_y_next;
      pair_count  <= pair_next;
      point_count <= point_next;
    end
  end

  // batch totals frozen while the divide runs
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      snap_min_x     <= min_x_next;
      snap_max_x     <= max_x_next;
      snap_min_y     <= min_y_next;
      snap_max_y     <= max_y_next;
      snap_points    <= point_next;
      snap_has_pairs <= pair_next != '0;
    end
  end

  // margin: extent register, then multiply register
  assign prod_x = PROD_W'(ext_x) * PROD_W'(MARGIN_MULT);
  assign prod_y = PROD_W'(ext_y) * PROD_W'(MARGIN_MULT);

  always_ff @(posedge clk) begin
    ext_x  <= COORD_W'(snap_max_x - snap_min_x);
    ext_y  <= COORD_W'(snap_max_y - snap_min_y);
    marg_x <= prod_x[PROD_W-1:MARGIN_SHIFT];
    marg_y <= prod_y[PROD_W-1:MARGIN_SHIFT];
  end

  bbs_divider u_div_x (
    .clk    (clk),
    .start  (cmd.finish),
    .step   (cmd.div_step),
    .num_in ({sum_x_next, 1'b0}),
    .den_in (pair_next),
    .quo    (quo_x)
  );

  bbs_divider u_div_y (
    .clk    (clk),
    .start  (cmd.finish),
    .step   (cmd.div_step),
    .num_in ({sum_y_next, 1'b0}),
    .den_in (pair_next),
    .quo    (quo_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      box_min_x     <= BOX_W'(snap_min_x) - BOX_W'(marg_x);
      box_max_x     <= BOX_W'(snap_max_x) + BOX_W'(marg_x);
      box_min_y     <= BOX_W'(snap_min_y) - BOX_W'(marg_y);
      box_max_y     <= BOX_W'(snap_max_y) + BOX_W'(marg_y);
      grid_x        <= snap_has_pairs ? quo_x[GRID_W-1:0] : '0;
      grid_y        <= snap_has_pairs ? quo_y[GRID_W-1:0] : '0;
      total_points  <= snap_points;
      spacing_valid <= snap_has_pairs;
    end
  end

endmodule

// ===== hdl/bbs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: controller
// Accept points, run the divide sequence, hand the result to the output reg.
// ---------------------------------------------------------------------------
module bbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_is_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output bbs_pkg::cmd_t cmd
);
  import bbs_pkg::*;

  localparam logic [1:0] S_ACCUM = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_HOLD  = 2'd2;

  logic [1:0]        state;
  logic [DCNT_W-1:0] step_cnt;
  logic              out_free;

  assign in_ready     = state == S_ACCUM;
  assign out_free     = !out_valid || out_ready;
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.finish   = cmd.accept && in_is_last;
  assign cmd.div_step = state == S_DIV;
  assign cmd.out_load = (state == S_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACCUM;
      step_cnt <= '0;
    end else begin
      case (state)
        S_ACCUM: begin
          if (cmd.finish) begin
            state    <= S_DIV;
            step_cnt <= '0;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_ACCUM;
          end
        end
        default: begin
          state <= S_ACCUM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/bounding_box_and_spacing.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: top level
// Survey-point batch to padded bounding box and mean neighbor spacing.
// ---------------------------------------------------------------------------
// Points stream in one per clock while in_ready is high. Each accepted point
// updates the running x/y extremes and, when it is a neighbor of the
// previous point under the spacing_mode rule, the absolute step sums and
// pair count. The point that carries is_last closes the batch: the
// accumulators are cleared in that same cycle and the totals move into a
// finishing stage, so in_ready drops while two radix-2 dividers (one
// quotient bit per cycle, 58 bits) form 2*sum/pairs. The result then sits
// in the output register; a new batch may stream in while it waits, and
// only that batch's finishing stage waits for the output register to empty,
// with in_ready low meanwhile. One point per cycle outside finishing stages.
// spacing_mode may be written whenever no batch is open and no result
// is pending; cfg.ready is always high.
// ---------------------------------------------------------------------------
module bounding_box_and_spacing (
  input  logic     clk,
  input  logic     rst,
  bbs_cfg_if.sink  cfg,
  bbs_in_if.sink   points,
  bbs_out_if.source result
);
  import bbs_pkg::*;

  cmd_t cmd;

  // Config is a single register, so a write transaction completes at once.
  assign cfg.ready = 1'b1;

  bbs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (points.valid),
    .in_is_last (points.is_last),
    .in_ready   (points.ready),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .cmd        (cmd)
  );

  // Datapath: accumulators, margin multiply, dividers and the result register.
  bbs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg.valid),
    .cfg_mode      (cfg.spacing_mode),
    .x_coord       (points.x_coord),
    .y_coord       (points.y_coord),
    .record_number (points.record_number),
    .sub_record    (points.sub_record),
    .box_min_x     (result.box_min_x),
    .box_max_x     (result.box_max_x),
    .box_min_y     (result.box_min_y),
    .box_max_y     (result.box_max_y),
    .grid_x        (result.grid_x),
    .grid_y        (result.grid_y),
    .total_points  (result.total_points),
    .spacing_valid (result.spacing_valid)
  );

endmodule

// ===== hdl/bbs_checker.sv =====
// ---------------------------------------------------------------------------
// Bounding box and spacing: port checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "bounding_box_and_spacing_assert.svh"

module bbs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_is_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bbs_pkg::BOX_W-1:0]  box_min_x,
  input logic signed [bbs_pkg::BOX_W-1:0]  box_max_x,
  input logic [bbs_pkg::GRID_W-1:0]        grid_x,
  input logic [bbs_pkg::GRID_W-1:0]        grid_y,
  input logic [bbs_pkg::CNT_W-1:0]         total_points,
  input logic                              spacing_valid
);
  import bbs_pkg::*;

  `BBS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `BBS_ASSERT(a_last_stalls, clk, rst, in_valid && in_ready && in_is_last |=> !in_ready)
  `BBS_ASSERT(a_no_pairs_zero, clk, rst, out_valid && !spacing_valid |-> grid_x == '0 && grid_y == '0)
  `BBS_ASSERT(a_box_order, clk, rst, out_valid |-> box_min_x <= box_max_x && total_points != '0)
  `BBS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind bounding_box_and_spacing bbs_checker u_bbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (points.valid),
  .in_ready      (points.ready),
  .in_is_last    (points.is_last),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .box_min_x     (result.box_min_x),
  .box_max_x     (result.box_max_x),
  .grid_x        (result.grid_x),
  .grid_y        (result.grid_y),
  .total_points  (result.total_points),
  .spacing_valid (result.spacing_valid)
);

// ===== dv/bbs_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bounding box and spacing: result checker
// Watches the configuration, point and result channels. It keeps its own
// running box and step sums, predicts each batch result and compares.
// ---------------------------------------------------------------------------
module bbs_scoreboard (
  input  logic clk,
  input  logic rst,
  bbs_cfg_if   cfg,
  bbs_in_if    points,
  bbs_out_if   result,
  output int   fail_count,
  output int   outstanding
);
  import bbs_pkg::*;

  typedef struct packed {
    logic signed [BOX_W-1:0] box_min_x;
    logic signed [BOX_W-1:0] box_max_x;
    logic signed [BOX_W-1:0] box_min_y;
    logic signed [BOX_W-1:0] box_max_y;
    logic [GRID_W-1:0]       grid_x;
    logic [GRID_W-1:0]       grid_y;
    logic [CNT_W-1:0]        total_points;
    logic                    spacing_valid;
  } batch_box_t;

  batch_box_t pending_boxes[$];

  logic [MODE_W-1:0]         mode;
  logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [COORD_W-1:0] last_x, last_y;
  logic [REC_W-1:0]          last_rec;
  logic [SUB_W-1:0]          last_sub;
  logic                      seen_one;
  logic [SUM_W-1:0]          steps_x, steps_y;
  logic [CNT_W-1:0]          pairs, npts;
  int                        errors;

  assign fail_count = errors;

  task automatic clear_batch();
    lo_x     = COORD_POS_MAX;
    hi_x     = COORD_NEG_MAX;
    lo_y     = COORD_POS_MAX;
    hi_y     = COORD_NEG_MAX;
    last_x   = '0;
    last_y   = '0;
    last_rec = '0;
    last_sub = '0;
    seen_one = 1'b0;
    steps_x  = '0;
    steps_y  = '0;
    pairs    = '0;
    npts     = '0;
  endtask

  // One line per mismatch
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Fold one accepted point into the batch; the closing point yields a box
  task automatic fold_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [REC_W-1:0] rec,
                            input logic [SUB_W-1:0] sub,
                            input logic last);
    longint               d_rec, d_sub, d_x, d_y, ext, marg;
    logic                 near;
    logic [NUM_W-1:0]     twice;
    batch_box_t           box;
    if (x < lo_x) lo_x = x;
    if (x > hi_x) hi_x = x;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;

    near = 1'b0;
    if (seen_one) begin
      // record distance is a true difference, no wrap
      d_rec = longint'(rec) - longint'(last_rec);
      if (d_rec < 0) d_rec = -d_rec;
      d_sub = longint'(sub) - longint'(last_sub);
      if (d_sub < 0) d_sub = -d_sub;
      case (mode)
        MODE_SAME_REC: near = (rec == last_rec) && (d_sub < NEAR_LIMIT);
        MODE_NEAR_REC: near = d_rec < NEAR_LIMIT;
        default:       near = 1'b0;
      endcase
    end
    if (near && pairs < CNT_W'(MAX_POINTS - 1)) begin
      d_x = longint'(x) - longint'(last_x);
      if (d_x < 0) d_x = -d_x;
      d_y = longint'(y) - longint'(last_y);
      if (d_y < 0) d_y = -d_y;
      steps_x = steps_x + SUM_W'(d_x);
      steps_y = steps_y + SUM_W'(d_y);
      pairs   = pairs + 1'b1;
    end
    if (npts < CNT_W'(MAX_POINTS)) npts = npts + 1'b1;

    last_x   = x;
    last_y   = y;
    last_rec = rec;
    last_sub = sub;
    seen_one = 1'b1;

    if (last) begin
      ext = longint'(hi_x) - longint'(lo_x);
      marg = (ext * MARGIN_MULT) >>> MARGIN_SHIFT;
      box.box_min_x = BOX_W'(longint'(lo_x) - marg);
      box.box_max_x = BOX_W'(longint'(hi_x) + marg);
      ext = longint'(hi_y) - longint'(lo_y);
      marg = (ext * MARGIN_MULT) >>> MARGIN_SHIFT;
      box.box_min_y = BOX_W'(longint'(lo_y) - marg);
      box.box_max_y = BOX_W'(longint'(hi_y) + marg);
      if (pairs != 0) begin
        twice       = {steps_x, 1'b0};
        box.grid_x  = GRID_W'(twice / pairs);
        twice       = {steps_y, 1'b0};
        box.grid_y  = GRID_W'(twice / pairs);
      end else begin
        box.grid_x  = '0;
        box.grid_y  = '0;
      end
      box.total_points  = npts;
      box.spacing_valid = (pairs != 0);
      pending_boxes.push_back(box);
      clear_batch();
    end
  endtask

  task automatic compare_result();
    batch_box_t want;
    if (pending_boxes.size() == 0) begin
      report_mismatch("unexpected result", 64'(result.total_points), 64'd0);
    end else begin
      want = pending_boxes.pop_front();
      check_field("box_min_x", 64'(result.box_min_x), 64'(want.box_min_x));
      check_field("box_max_x", 64'(result.box_max_x), 64'(want.box_max_x));
      check_field("box_min_y", 64'(result.box_min_y), 64'(want.box_min_y));
      check_field("box_max_y", 64'(result.box_max_y), 64'(want.box_max_y));
      check_field("grid_x", 64'(result.grid_x), 64'(want.grid_x));
      check_field("grid_y", 64'(result.grid_y), 64'(want.grid_y));
      check_field("total_points", 64'(result.total_points), 64'(want.total_points));
      check_field("spacing_valid", 64'(result.spacing_valid), 64'(want.spacing_valid));
    end
  endtask

  initial begin
    errors = 0;
    mode   = MODE_SAME_REC;
    clear_batch();
  end

  // results first: one leaving the block never belongs to a point taken now
  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_SAME_REC;
      clear_batch();
      pending_boxes.delete();
    end else begin
      if (result.valid && result.ready) compare_result();
      if (cfg.valid && cfg.ready) mode = cfg.spacing_mode;
      if (points.valid && points.ready) begin
        fold_point(points.x_coord, points.y_coord, points.record_number,
                   points.sub_record, points.is_last);
      end
    end
    outstanding <= pending_boxes.size();
  end

endmodule

// ===== dv/tb_bounding_box_and_spacing.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bounding box and spacing: testbench top
// Drives point batches under every spacing mode, directed edge cases first,
// then random batches with stalls on both sides; bbs_scoreboard does the scoring.
// ---------------------------------------------------------------------------
module tb_bounding_box_and_spacing;
  import bbs_pkg::*;

  // Mode code the block does not define; must act like MODE_NO_SPACE
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 10;
  localparam int PHASE_POINTS = 143;    // ~1430 random points overall
  localparam int HOLD_CYCLES  = 600;    // long result back-pressure
  localparam int DRAIN_CYCLES = 70;

  logic clk;
  logic rst;
  logic calm;      // no idling on either side while set
  logic hold_req;
  logic holding;   // receiver held off
  int   fail_count;
  int   outstanding;
  int   points_sent;
  int   batches_sent;
  int   cycles;

  bbs_cfg_if cfg_ch ();
  bbs_in_if  points_ch ();
  bbs_out_if result_ch ();

  bounding_box_and_spacing dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .points (points_ch),
    .result (result_ch)
  );

  bbs_scoreboard u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .points      (points_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, none during the calm stretch, and ready held low
  // for the whole long hold-off
  always @(posedge clk) begin
    result_ch.ready <= !holding && (calm || $urandom_range(99) >= 24);
  end

  // Long hold-off, timed here; the sender keeps offering points meanwhile so
  // a finished result holds the next batch in its finishing stage
  initial begin
    holding = 1'b0;
    wait (hold_req);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // Offer one point and return at the edge that takes it. valid stays high
  // so the next call can go on back to back without a low/high pair in one
  // step.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [REC_W-1:0] rec,
                            input logic [SUB_W-1:0] sub,
                            input logic last);
    while (!calm && $urandom_range(99) < 24) begin
      points_ch.valid <= 1'b0;
      @(posedge clk);
    end
    points_ch.valid         <= 1'b1;
    points_ch.x_coord       <= x;
    points_ch.y_coord       <= y;
    points_ch.record_number <= rec;
    points_ch.sub_record    <= sub;
    points_ch.is_last       <= last;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    points_sent++;
    if (last) batches_sent++;
  endtask

  // Mode change only with the block idle: every result back, then a margin
  task automatic set_mode(input logic [MODE_W-1:0] m);
    points_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.spacing_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly small steps so neighbors stay close; now and then a jump or a rail
  function automatic logic signed [COORD_W-1:0] wander(logic signed [COORD_W-1:0] c);
    case ($urandom_range(19))
      0, 1:    return $urandom;
      2:       return COORD_NEG_MAX;
      3:       return COORD_POS_MAX;
      default: return c + COORD_W'($urandom_range(4000)) - COORD_W'(2000);
    endcase
  endfunction

  // One batch. Well-formed batches walk record and sub-record by small steps
  // (plus the odd jump) so pairs land on both sides of the distance limit;
  // noisy ones draw every field fresh.
  task automatic run_batch(input bit noisy);
    int                        n;
    logic signed [COORD_W-1:0] x, y;
    logic [REC_W-1:0]          rec;
    logic [SUB_W-1:0]          sub;
    n = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    // start near the ends of the record and sub-record ranges now and then
    case ($urandom_range(7))
      0:       rec = REC_W'($urandom_range(3));
      1:       rec = {REC_W{1'b1}} - REC_W'($urandom_range(3));
      default: rec = $urandom;
    endcase
    case ($urandom_range(7))
      0:       sub = SUB_W'($urandom_range(3));
      1:       sub = {SUB_W{1'b1}} - SUB_W'($urandom_range(3));
      default: sub = SUB_W'($urandom);
    endcase
    x = $urandom;
    y = $urandom;
    for (int k = 0; k < n; k++) begin
      if (k != 0) begin
        if (noisy) begin
          rec = $urandom;
          sub = SUB_W'($urandom);
          x   = $urandom;
          y   = $urandom;
        end else begin
          case ($urandom_range(9))
            5:       rec = rec + 1'b1;
            6:       rec = rec - 2'd2;
            7:       rec = rec + 2'd3;
            8:       rec = rec - 2'd3;
            9:       rec = $urandom;
            default: ;
          endcase
          if ($urandom_range(9) == 0) sub = SUB_W'($urandom);
          else sub = sub + SUB_W'($urandom_range(6)) - SUB_W'(3);
          x = wander(x);
          y = wander(y);
        end
      end
      send_point(x, y, rec, sub, k == n - 1);
    end
  endtask

  initial begin
    int                start_pts;
    logic [MODE_W-1:0] m;

    points_sent  = 0;
    batches_sent = 0;
    rst      = 1'b1;
    calm     = 1'b0;
    hold_req = 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.spacing_mode     <= MODE_SAME_REC;
    points_ch.valid         <= 1'b0;
    points_ch.x_coord       <= '0;
    points_ch.y_coord       <= '0;
    points_ch.record_number <= '0;
    points_ch.sub_record    <= '0;
    points_ch.is_last       <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed, mode left at its reset value (same record, near sub) ---
    // lone point: no predecessor, so no spacing and a zero-width box
    send_point(COORD_NEG_MAX, COORD_POS_MAX, {REC_W{1'b1}}, {SUB_W{1'b1}}, 1'b1);
    // full coordinate span both ways: largest step, extent and margin
    send_point(COORD_NEG_MAX, COORD_POS_MAX, 32'd5, 16'd10, 1'b0);
    send_point(COORD_POS_MAX, COORD_NEG_MAX, 32'd5, 16'd12, 1'b1);
    // sub-record gap at, under and across the limit; record change; no wrap
    send_point(32'sd0,  32'sd0,   32'd7, 16'd0,     1'b0);
    send_point(32'sd10, -32'sd10, 32'd7, 16'd3,     1'b0);
    send_point(32'sd20, -32'sd5,  32'd7, 16'd1,     1'b0);
    send_point(32'sd25, 32'sd0,   32'd8, 16'd1,     1'b0);
    send_point(32'sd30, 32'sd3,   32'd8, 16'hFFFF,  1'b0);
    send_point(32'sd31, 32'sd4,   32'd8, 16'hFFFE,  1'b1);

    // near-record rule: gap 2 counts, gap 3 does not, no wrap at the top
    set_mode(MODE_NEAR_REC);
    send_point(32'sd100, 32'sd100, 32'd0,        16'd0, 1'b0);
    send_point(32'sd90,  32'sd110, 32'd2,        16'd5, 1'b0);
    send_point(32'sd80,  32'sd80,  32'd5,        16'd5, 1'b0);
    send_point(32'sd70,  32'sd70,  32'hFFFFFFFF, 16'd0, 1'b0);
    send_point(32'sd71,  32'sd60,  32'hFFFFFFFD, 16'd9, 1'b0);
    send_point(-32'sd1,  -32'sd1,  32'hFFFFFFFE, 16'd0, 1'b1);

    // spacing off, then the undefined code that must behave the same way
    set_mode(MODE_NO_SPACE);
    send_point(32'sd1, 32'sd2, 32'd3, 16'd4, 1'b0);
    send_point(32'sd5, 32'sd6, 32'd3, 16'd4, 1'b1);
    set_mode(MODE_UNUSED);
    send_point(32'sd1, 32'sd2, 32'd3, 16'd4, 1'b0);
    send_point(32'sd5, 32'sd6, 32'd3, 16'd4, 1'b1);

    // --- random phases, one mode each; the first four walk every code ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: m = MODE_SAME_REC;
        1: m = MODE_NEAR_REC;
        2: m = MODE_UNUSED;
        3: m = MODE_NO_SPACE;
        default: begin
          case ($urandom_range(9))
            0, 1, 2, 3: m = MODE_SAME_REC;
            4, 5, 6, 7: m = MODE_NEAR_REC;
            8:          m = MODE_NO_SPACE;
            default:    m = MODE_UNUSED;
          endcase
        end
      endcase
      set_mode(m);
      // phase 1: long receiver hold-off; phase 4: a stretch with no idling
      if (ph == 1) hold_req <= 1'b1;
      calm <= (ph == 4);
      start_pts = points_sent;
      while (points_sent - start_pts < PHASE_POINTS) begin
        run_batch($urandom_range(99) < 20);
      end
    end

    points_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d points in %0d batches, spacing codes 0-3, random stalls both sides,",
             points_sent, batches_sent);
    $display("     and a %0d-cycle result hold-off with the sender still pushing.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
